// ===== sv/cfir_pkg.sv =====
`default_nettype none
package cfir_pkg;

  // Operation codes carried in tuser.
  typedef enum logic {
    OP_FILTER = 1'b0,
    OP_LOAD   = 1'b1
  } op_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_MAC,
    S_DRAIN,
    S_ROUND,
    S_OUT
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic take_input;
    logic tap_write;
    logic hist_clear;
    logic acc_clear;
    logic mac_issue;
    logic mac_first;
    logic hist_write;
    logic round_go;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic op_load;
    logic index_ok;
  } stat_t;

endpackage
`default_nettype wire

// ===== sv/cfir_ram.sv =====
`default_nettype none
module cfir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/cfir_ctrl.sv =====
`default_nettype none
module cfir_ctrl #(
  parameter int TAPS = 1025
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire cfir_pkg::stat_t      stat,
  output cfir_pkg::cmd_t            cmd,
  output logic [$clog2(TAPS)-1:0]   k
);

  localparam int KW = $clog2(TAPS);
  localparam int HD = TAPS - 1;

  cfir_pkg::state_t state, state_next;
  logic [KW-1:0] k_next;
  logic [1:0] drain, drain_next;

  // State, tap counter and drain counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cfir_pkg::S_CLEAR;
      k     <= '0;
      drain <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
      drain <= drain_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    k_next     = k;
    drain_next = drain;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      cfir_pkg::S_CLEAR: begin
        cmd.hist_clear = 1'b1;
        if (k == KW'(HD - 1)) begin
          k_next     = '0;
          state_next = cfir_pkg::S_IDLE;
        end else begin
          k_next = k + 1'b1;
        end
      end
      cfir_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_input = 1'b1;
          if (stat.op_load) begin
            cmd.tap_write = stat.index_ok;
          end else begin
            cmd.acc_clear = 1'b1;
            k_next        = '0;
            state_next    = cfir_pkg::S_MAC;
          end
        end
      end
      cfir_pkg::S_MAC: begin
        cmd.mac_issue = 1'b1;
        cmd.mac_first = (k == '0);
        if (k == KW'(TAPS - 1)) begin
          drain_next = '0;
          state_next = cfir_pkg::S_DRAIN;
        end else begin
          k_next = k + 1'b1;
        end
      end
      cfir_pkg::S_DRAIN: begin
        if (drain == 2'd3) begin
          cmd.hist_write = 1'b1;
          state_next     = cfir_pkg::S_ROUND;
        end else begin
          drain_next = drain + 1'b1;
        end
      end
      cfir_pkg::S_ROUND: begin
        cmd.round_go = 1'b1;
        state_next   = cfir_pkg::S_OUT;
      end
      cfir_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = cfir_pkg::S_IDLE;
        end
      end
      default: state_next = cfir_pkg::S_IDLE;
    endcase
  end

  // Tap counter never passes the last tap.
  assert property (@(posedge clk) disable iff (rst)
    state == cfir_pkg::S_MAC |-> k <= KW'(TAPS - 1))
    else $error("tap counter out of range");

  // A new item is taken only when no result waits.
  assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input and output both open");

  // A result follows the round step.
  assert property (@(posedge clk) disable iff (rst)
    state == cfir_pkg::S_ROUND |=> out_valid)
    else $error("result missing after rounding");

endmodule
`default_nettype wire

// ===== sv/cfir_datapath.sv =====
`default_nettype none
module cfir_datapath #(
  parameter int TAPS        = 1025,
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire cfir_pkg::cmd_t                cmd,
  input  wire logic [$clog2(TAPS)-1:0]       k,
  input  wire logic                          op,
  input  wire logic signed [SAMPLE_BITS-1:0] s_re,
  input  wire logic signed [SAMPLE_BITS-1:0] s_im,
  input  wire logic [10:0]                   t_idx,
  input  wire logic signed [COEF_BITS-1:0]   t_re,
  input  wire logic signed [COEF_BITS-1:0]   t_im,
  output cfir_pkg::stat_t                    stat,
  output logic signed [SAMPLE_BITS-1:0]      y_re,
  output logic signed [SAMPLE_BITS-1:0]      y_im,
  output logic                               y_clip
);

  localparam int KW  = $clog2(TAPS);
  localparam int HD  = TAPS - 1;
  localparam int HW  = (HD > 1) ? $clog2(HD) : 1;
  localparam int PW  = SAMPLE_BITS + COEF_BITS + 1;
  localparam int AW  = PW + KW + 1;
  localparam int SW  = 2 * SAMPLE_BITS;
  localparam int CW  = 2 * COEF_BITS;

  logic [HW-1:0] hpos;
  logic signed [SAMPLE_BITS-1:0] x_re, x_im;

  // Write position and latched current sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      hpos <= '0;
    end else if (cmd.hist_write) begin
      hpos <= (hpos == HW'(HD - 1)) ? '0 : hpos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_input) begin
      x_re <= s_re;
      x_im <= s_im;
    end
  end

  assign stat.op_load  = (op == cfir_pkg::OP_LOAD);
  assign stat.index_ok = ({{(KW + 12){1'b0}}, t_idx} < (KW + 23)'(TAPS));

  // History read address: (hpos - k) modulo the history depth.
  logic [HW:0] raddr_w;
  logic [HW-1:0] h_raddr, h_waddr;
  always_comb begin
    raddr_w = {1'b0, hpos} - (HW + 1)'(k);
    if (raddr_w[HW] || k > KW'(hpos)) begin
      raddr_w = raddr_w + (HW + 1)'(HD);
    end
    h_raddr = raddr_w[HW-1:0];
  end
  assign h_waddr = cmd.hist_clear ? k[HW-1:0] : hpos;

  logic [SW-1:0] h_rdata, c_rdata_s;
  logic [CW-1:0] c_rdata;

  cfir_ram #(.WIDTH(SW), .DEPTH(HD)) u_hist (
    .clk   (clk),
    .we    (cmd.hist_clear || cmd.hist_write),
    .waddr (h_waddr),
    .wdata (cmd.hist_clear ? '0 : {x_im, x_re}),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  cfir_ram #(.WIDTH(CW), .DEPTH(TAPS)) u_taps (
    .clk   (clk),
    .we    (cmd.tap_write),
    .waddr (t_idx[KW-1:0]),
    .wdata ({t_im, t_re}),
    .raddr (k),
    .rdata (c_rdata)
  );
  assign c_rdata_s = h_rdata;

  // Stage 1: memory read returns; tag whether this is the current sample.
  logic v1, f1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= cmd.mac_issue;
    end
    f1 <= cmd.mac_first;
  end

  logic signed [SAMPLE_BITS-1:0] a_re, a_im;
  logic signed [COEF_BITS-1:0] c_re, c_im;
  always_comb begin
    a_re = f1 ? x_re : c_rdata_s[SAMPLE_BITS-1:0];
    a_im = f1 ? x_im : c_rdata_s[SW-1:SAMPLE_BITS];
    c_re = c_rdata[COEF_BITS-1:0];
    c_im = c_rdata[CW-1:COEF_BITS];
  end

  // Stage 2: four partial products, registered.
  logic v2;
  logic signed [PW-2:0] p_rr, p_ii, p_ri, p_ir;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    p_rr <= c_re * a_re;
    p_ii <= c_im * a_im;
    p_ri <= c_re * a_im;
    p_ir <= c_im * a_re;
  end

  // Stage 3: accumulate.
  logic signed [AW-1:0] acc_re, acc_im;
  always_ff @(posedge clk) begin
    if (cmd.acc_clear) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (v2) begin
      acc_re <= acc_re + AW'(p_rr) - AW'(p_ii);
      acc_im <= acc_im + AW'(p_ri) + AW'(p_ir);
    end
  end

  // Round, shift and saturate.
  localparam logic signed [AW-1:0] HALF = AW'(1) <<< (COEF_BITS - 2);
  localparam logic signed [AW-1:0] HI = (AW'(1) <<< (SAMPLE_BITS - 1)) - AW'(1);
  localparam logic signed [AW-1:0] LO = -(AW'(1) <<< (SAMPLE_BITS - 1));
  logic signed [AW-1:0] r_re, r_im;
  logic hi_re, lo_re, hi_im, lo_im;
  always_comb begin
    r_re  = (acc_re + HALF) >>> (COEF_BITS - 1);
    r_im  = (acc_im + HALF) >>> (COEF_BITS - 1);
    hi_re = r_re > HI;
    lo_re = r_re < LO;
    hi_im = r_im > HI;
    lo_im = r_im < LO;
  end

  always_ff @(posedge clk) begin
    if (cmd.round_go) begin
      y_re   <= hi_re ? HI[SAMPLE_BITS-1:0] : (lo_re ? LO[SAMPLE_BITS-1:0]
                                                     : r_re[SAMPLE_BITS-1:0]);
      y_im   <= hi_im ? HI[SAMPLE_BITS-1:0] : (lo_im ? LO[SAMPLE_BITS-1:0]
                                                     : r_im[SAMPLE_BITS-1:0]);
      y_clip <= hi_re | lo_re | hi_im | lo_im;
    end
  end

  // A product is valid only after a valid memory read in stage 1.
  assert property (@(posedge clk) disable iff (rst) v2 |-> $past(v1))
    else $error("product without read");

  // History write position stays inside the store.
  assert property (@(posedge clk) disable iff (rst) hpos <= HW'(HD - 1))
    else $error("history position out of range");

  // With the clip flag clear, the real output is the rounded value as is.
  assert property (@(posedge clk) disable iff (rst)
    $past(cmd.round_go) && !y_clip |-> y_re == $past(r_re[SAMPLE_BITS-1:0]))
    else $error("unclipped value mismatch");

endmodule
`default_nettype wire

// ===== sv/complex_fir_block_convolver_unit.sv =====
`default_nettype none
// Complex FIR filter, direct form, one multiply-accumulate tap per cycle.
// Input channel s_axis: tuser is the operation (0 filter, 1 load tap);
// tdata carries sample and tap fields. A load item writes one tap and gives
// no result; indexes at or past TAPS are dropped. A filter item gives one
// result on m_axis: rounded, saturated real and imaginary parts in tdata,
// and the clipped flag in tuser.
// A filter item runs one tap product per clock from one tap RAM and one
// history RAM read port, then the product pipeline drains and the sum is
// rounded and shown on m_axis. A load item writes its tap from the idle
// state, which stays ready for the next item.
// After reset the block first clears every entry of the sample history
// with s_axis_tready low. A result holds on m_axis until taken; the block
// accepts no new item while a result waits.
module complex_fir_block_convolver_unit #(
  parameter int TAPS        = 1025,
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // sample_real, sample_imag, tap_index(11), tap_real, tap_imag, zero pad
  input  wire logic [((2*SAMPLE_BITS+11+2*COEF_BITS+7)/8)*8-1:0] s_axis_tdata,
  // operation
  input  wire logic                                  s_axis_tuser,
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // out_real, out_imag
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]         m_axis_tdata,
  // clipped
  output logic                                       m_axis_tuser
);

  localparam int KW = $clog2(TAPS);
  localparam int S0 = 0;
  localparam int S1 = SAMPLE_BITS;
  localparam int TI = 2 * SAMPLE_BITS;
  localparam int T0 = TI + 11;
  localparam int T1 = T0 + COEF_BITS;
  localparam int OW = ((2 * SAMPLE_BITS + 7) / 8) * 8;

  cfir_pkg::cmd_t  cmd;
  cfir_pkg::stat_t stat;
  logic [KW-1:0] k;
  logic signed [SAMPLE_BITS-1:0] y_re, y_im;

  cfir_ctrl #(.TAPS(TAPS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd),
    .k         (k)
  );

  cfir_datapath #(
    .TAPS(TAPS), .SAMPLE_BITS(SAMPLE_BITS), .COEF_BITS(COEF_BITS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .k      (k),
    .op     (s_axis_tuser),
    .s_re   (s_axis_tdata[S0 +: SAMPLE_BITS]),
    .s_im   (s_axis_tdata[S1 +: SAMPLE_BITS]),
    .t_idx  (s_axis_tdata[TI +: 11]),
    .t_re   (s_axis_tdata[T0 +: COEF_BITS]),
    .t_im   (s_axis_tdata[T1 +: COEF_BITS]),
    .stat   (stat),
    .y_re   (y_re),
    .y_im   (y_im),
    .y_clip (m_axis_tuser)
  );

  assign m_axis_tdata = OW'({y_im, y_re});

endmodule
`default_nettype wire
